// ===== hdl/bmppru_pkg.sv =====
// bmppru_pkg: types and constants for the bitmap pixel row unpacker
// used by bmp_pixel_row_unpacker_unit, no dependencies
package bmppru_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_ROWS      = 4096;
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
   localparam int CFG_W         = 13;
   localparam int CNT_W         = 12;
   localparam int ADDR_W        = 4;
   localparam int DATA_W        = 32;

   localparam logic OP_PIXEL   = 1'b0;
   localparam logic OP_PALETTE = 1'b1;

   localparam logic MODE_DIRECT  = 1'b0;
   localparam logic MODE_PALETTE = 1'b1;

   localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
   localparam logic [1:0] REG_PIXEL_MODE = 2'd2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
      logic [7:0] entry_index;
      logic [7:0] entry_red;
      logic [7:0] entry_green;
      logic [7:0] entry_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       image_end;
   } rsp_type;

endpackage

// ===== hdl/bmp_pixel_row_unpacker_unit.sv =====
// bmp_pixel_row_unpacker_unit: bitmap pixel-array byte stream to rgb pixels
// depends on bmppru_pkg; palette held in a 256 x 24 synchronous ram
// a pixel's last byte passes the ram read stage and then the output register before rsp_valid rises
// throughput: one byte or palette write per cycle while req is not stalled; one palette ram read per pixel
// a two-entry path (ram read stage, output register); req stalls only when both are full
// reset: counters, phase, padding and registers cleared (width 1, count 1, direct mode)
// the palette ram is not cleared and reads undefined until written
module bmp_pixel_row_unpacker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bmppru_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bmppru_pkg::rsp_type                 rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bmppru_pkg::ADDR_W-1:0]       paddr,
   input  logic [bmppru_pkg::DATA_W-1:0]       pwdata,
   output logic [bmppru_pkg::DATA_W-1:0]       prdata,
   output logic                                pready
);
   import bmppru_pkg::*;

   typedef struct packed {
      logic        use_pal;
      logic [23:0] rgb;
      logic        row_end;
      logic        image_end;
   } stage_type;

   // configuration
   logic [CFG_W-1:0] row_width_ff, row_count_ff;
   logic             pixel_mode_ff;
   logic             cfg_write;

   // stream state
   logic [1:0]       byte_phase_ff, byte_phase_in;
   logic [15:0]      held_bytes_ff, held_bytes_in;
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [1:0]       pad_left_ff, pad_left_in;
   logic [CNT_W-1:0] row_index_ff, row_index_in;

   // pipeline
   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   logic             out_valid_ff;
   rsp_type          out_ff;
   logic [23:0]      rd_data_ff;
   logic [23:0]      pal_mem [PALETTE_DEPTH];

   logic             s1_move, req_xfer, is_pixel, emit, pal_read, pal_write;
   logic [CFG_W-1:0] eff_w, eff_h, col_next, row_next;
   logic [1:0]       row_bytes_lo;
   logic             last_col, last_row;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_comb begin
      case (paddr[3:2])
         REG_ROW_WIDTH:  prdata = {{(DATA_W-CFG_W){1'b0}}, row_width_ff};
         REG_ROW_COUNT:  prdata = {{(DATA_W-CFG_W){1'b0}}, row_count_ff};
         REG_PIXEL_MODE: prdata = {{(DATA_W-1){1'b0}}, pixel_mode_ff};
         default:        prdata = '0;
      endcase
   end

   assign s1_move   = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_move;
   assign req_xfer  = req_valid & req_ready;
   assign is_pixel  = req_data.opcode == OP_PIXEL;
   assign pal_write = req_xfer & (req_data.opcode == OP_PALETTE);

   // zero counts as one, larger values saturate
   assign eff_w = (row_width_ff == '0) ? CFG_W'(1) :
                  (row_width_ff > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : row_width_ff;
   assign eff_h = (row_count_ff == '0) ? CFG_W'(1) :
                  (row_count_ff > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_ff;

   assign col_next = {1'b0, column_count_ff} + CFG_W'(1);
   assign row_next = {1'b0, row_index_ff} + CFG_W'(1);
   assign last_col = col_next >= eff_w;
   assign last_row = row_next >= eff_h;

   // low two bits of the row length in bytes
   assign row_bytes_lo = (pixel_mode_ff == MODE_PALETTE) ? eff_w[1:0]
                                                         : 2'(eff_w[1:0] + {eff_w[0], 1'b0});

   assign emit     = req_xfer & is_pixel & (pad_left_ff == 2'd0) &
                     ((pixel_mode_ff == MODE_PALETTE) || (byte_phase_ff == 2'd2));
   assign pal_read = emit & (pixel_mode_ff == MODE_PALETTE);

   always_comb begin
      byte_phase_in   = byte_phase_ff;
      held_bytes_in   = held_bytes_ff;
      column_count_in = column_count_ff;
      pad_left_in     = pad_left_ff;
      row_index_in    = row_index_ff;
      s1_valid_in     = s1_valid_ff & ~s1_move;
      s1_in           = s1_ff;
      if (req_xfer && is_pixel) begin
         if (pad_left_ff != 2'd0) begin
            pad_left_in = pad_left_ff - 2'd1;
         end else if (pixel_mode_ff == MODE_PALETTE) begin
            byte_phase_in = 2'd0;
         end else begin
            case (byte_phase_ff)
               2'd1: begin
                  held_bytes_in = {req_data.data_byte, held_bytes_ff[7:0]};
                  byte_phase_in = 2'd2;
               end
               2'd2: byte_phase_in = 2'd0;
               default: begin
                  held_bytes_in = {8'd0, req_data.data_byte};
                  byte_phase_in = 2'd1;
               end
            endcase
         end
      end
      if (emit) begin
         s1_valid_in       = 1'b1;
         s1_in.use_pal     = pixel_mode_ff == MODE_PALETTE;
         s1_in.rgb         = {req_data.data_byte, held_bytes_ff[15:8], held_bytes_ff[7:0]};
         s1_in.row_end     = last_col;
         s1_in.image_end   = last_col & last_row;
         if (last_col) begin
            column_count_in = '0;
            pad_left_in     = 2'(2'd0 - row_bytes_lo);
            row_index_in    = last_row ? '0 : row_next[CNT_W-1:0];
         end else begin
            column_count_in = col_next[CNT_W-1:0];
         end
      end
   end

   // palette ram: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pal_write) begin
         pal_mem[req_data.entry_index[PAL_ADDR_W-1:0]] <=
            {req_data.entry_red, req_data.entry_green, req_data.entry_blue};
      end
      if (pal_read) begin
         rd_data_ff <= pal_mem[req_data.data_byte[PAL_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= CFG_W'(1);
         row_count_ff    <= CFG_W'(1);
         pixel_mode_ff   <= MODE_DIRECT;
         byte_phase_ff   <= '0;
         held_bytes_ff   <= '0;
         column_count_ff <= '0;
         pad_left_ff     <= '0;
         row_index_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (cfg_write) begin
            case (paddr[3:2])
               REG_ROW_WIDTH:  row_width_ff  <= pwdata[CFG_W-1:0];
               REG_ROW_COUNT:  row_count_ff  <= pwdata[CFG_W-1:0];
               REG_PIXEL_MODE: pixel_mode_ff <= pwdata[0];
               default: ;
            endcase
         end
         byte_phase_ff   <= byte_phase_in;
         held_bytes_ff   <= held_bytes_in;
         column_count_ff <= column_count_in;
         pad_left_ff     <= pad_left_in;
         row_index_ff    <= row_index_in;
         s1_valid_ff     <= s1_valid_in;
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_move) begin
         {out_ff.red, out_ff.green, out_ff.blue} <= s1_ff.use_pal ? rd_data_ff : s1_ff.rgb;
         out_ff.row_end   <= s1_ff.row_end;
         out_ff.image_end <= s1_ff.image_end;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_image_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.image_end || rsp_data.row_end))
      else $error("image_end without row_end");

   a_pad_only_at_pixel_boundary: assert property (@(posedge clock) disable iff (reset)
      pad_left_ff != 2'd0 |-> byte_phase_ff == 2'd0)
      else $error("padding pending inside a pixel");

   a_ram_data_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move && s1_ff.use_pal) |=> $stable(rd_data_ff))
      else $error("palette read data lost while stalled");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!s1_valid_ff || s1_move))
      else $error("pixel issued into a full stage");
`endif

endmodule
